FILE: sv/bqd_pkg.sv
// ----------------------------------------------------------------------------
// bqd_pkg
// Shared constants for the biquad filter unit: default widths, register map.
// ----------------------------------------------------------------------------
`default_nettype none

package bqd_pkg;

	localparam int DATA_WIDTH_DEF = 24;
	localparam int COEF_WIDTH_DEF = 32;
	localparam int NUM_COEFS      = 5;
	localparam int COEF_INT_BITS  = 4;

	// register indexes, one apb word each
	localparam logic [2:0] REG_B0 = 3'd0;
	localparam logic [2:0] REG_B1 = 3'd1;
	localparam logic [2:0] REG_B2 = 3'd2;
	localparam logic [2:0] REG_A1 = 3'd3;
	localparam logic [2:0] REG_A2 = 3'd4;

endpackage

`default_nettype wire

FILE: sv/bqd_sample_if.sv
// ----------------------------------------------------------------------------
// bqd_sample_if
// Valid/ready channel carrying one input sample and its clear flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface bqd_sample_if
	import bqd_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] sample_in;
	logic                         clear_state;

	modport source (output valid, output sample_in, output clear_state, input ready);
	modport sink   (input valid, input sample_in, input clear_state, output ready);
endinterface

`default_nettype wire

FILE: sv/bqd_result_if.sv
// ----------------------------------------------------------------------------
// bqd_result_if
// Valid/ready channel carrying one filtered output sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface bqd_result_if
	import bqd_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

FILE: sv/biquad_iir_filter_unit.sv
// ----------------------------------------------------------------------------
// biquad_iir_filter_unit
// Second-order iir section, transposed direct form ii, one shared multiplier.
// ----------------------------------------------------------------------------
//  channel    | dir | handshake       | payload
//  -----------+-----+-----------------+-------------------------------------
//  sample_ch  | in  | valid / ready   | sample_in (signed), clear_state
//  result_ch  | out | valid / ready   | sample_out (signed, rounded, saturated)
//  apb        | in  | psel / penable  | coef_b0 b1 b2 a1 a2, signed q3.(W-4)
//
//  each item: accept, then six multiplies/updates on the single
//  shared multiplier (b0*x, b1*x, a1*y, b2*x, a2*y with the adds in between),
//  then a load into the output register.
//  the output register lets a finished result wait; the sequencer stalls in
//  its last step only while that register is still full.
//  reset clears both delays, the control state and sets b0 to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_iir_filter_unit
	import bqd_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int COEF_WIDTH = COEF_WIDTH_DEF,
	localparam int PDATA_W   = (COEF_WIDTH > 32) ? 64 : 32,
	localparam int ADDR_SH   = (COEF_WIDTH > 32) ? 3 : 2,
	localparam int PADDR_W   = ADDR_SH + $clog2(NUM_COEFS)
) (
	input  wire                 clk,
	input  wire                 arst_n,

	bqd_sample_if.sink          sample_ch,
	bqd_result_if.source        result_ch,

	input  wire                 psel,
	input  wire                 penable,
	input  wire                 pwrite,
	input  wire [PADDR_W-1:0]   paddr,
	input  wire [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	localparam int ACC_WIDTH = DATA_WIDTH + COEF_WIDTH;
	localparam int COEF_FRAC = COEF_WIDTH - COEF_INT_BITS;
	localparam int IDX_W     = PADDR_W - ADDR_SH;
	localparam int SH_W      = ACC_WIDTH + 2 - COEF_FRAC;

	localparam logic signed [ACC_WIDTH+1:0] ACC_MAX_X = {3'b000, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_WIDTH+1:0] ACC_MIN_X = {3'b111, {(ACC_WIDTH-1){1'b0}}};
	localparam logic signed [SH_W-1:0] DAT_MAX_X =
		{{(SH_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [SH_W-1:0] DAT_MIN_X =
		{{(SH_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
	localparam logic signed [ACC_WIDTH+1:0] RND_HALF =
		{{(ACC_WIDTH+2-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_B0   = 8'b0000_0010,
		S_Y    = 8'b0000_0100,
		S_A1   = 8'b0000_1000,
		S_D1   = 8'b0001_0000,
		S_B2   = 8'b0010_0000,
		S_D2   = 8'b0100_0000,
		S_PUSH = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic signed [COEF_WIDTH-1:0] coef_b0_q, coef_b1_q, coef_b2_q, coef_a1_q, coef_a2_q;
	logic signed [DATA_WIDTH-1:0] x_q, y_q, out_data_q;
	logic signed [ACC_WIDTH-1:0]  delay_one_q, delay_two_q, prod_q;
	logic signed [ACC_WIDTH:0]    acc_q;
	logic                         out_vld_q;

	logic                         accept, cfg_wr, slot_free;
	logic [IDX_W-1:0]             cfg_idx;
	logic signed [DATA_WIDTH-1:0] mul_a;
	logic signed [COEF_WIDTH-1:0] mul_c;
	logic signed [ACC_WIDTH-1:0]  mul_p;
	logic signed [ACC_WIDTH+1:0]  sum_y, diff;
	logic signed [SH_W-1:0]       y_sh;
	logic signed [DATA_WIDTH-1:0] y_sat;
	logic signed [ACC_WIDTH-1:0]  d_sat;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_idx = paddr[PADDR_W-1:ADDR_SH];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_b0_q <= {{(COEF_INT_BITS-1){1'b0}}, 1'b1, {COEF_FRAC{1'b0}}};
			coef_b1_q <= '0;
			coef_b2_q <= '0;
			coef_a1_q <= '0;
			coef_a2_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				IDX_W'(REG_B0): coef_b0_q <= pwdata[COEF_WIDTH-1:0];
				IDX_W'(REG_B1): coef_b1_q <= pwdata[COEF_WIDTH-1:0];
				IDX_W'(REG_B2): coef_b2_q <= pwdata[COEF_WIDTH-1:0];
				IDX_W'(REG_A1): coef_a1_q <= pwdata[COEF_WIDTH-1:0];
				IDX_W'(REG_A2): coef_a2_q <= pwdata[COEF_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			IDX_W'(REG_B0): prdata = PDATA_W'(unsigned'(coef_b0_q));
			IDX_W'(REG_B1): prdata = PDATA_W'(unsigned'(coef_b1_q));
			IDX_W'(REG_B2): prdata = PDATA_W'(unsigned'(coef_b2_q));
			IDX_W'(REG_A1): prdata = PDATA_W'(unsigned'(coef_a1_q));
			IDX_W'(REG_A2): prdata = PDATA_W'(unsigned'(coef_a2_q));
			default:        prdata = '0;
		endcase
	end

	// ---------------- shared multiplier ----------------
	always_comb begin
		case (state_q)
			S_B0:    begin mul_a = x_q; mul_c = coef_b0_q; end
			S_Y:     begin mul_a = x_q; mul_c = coef_b1_q; end
			S_A1:    begin mul_a = y_q; mul_c = coef_a1_q; end
			S_D1:    begin mul_a = x_q; mul_c = coef_b2_q; end
			S_B2:    begin mul_a = y_q; mul_c = coef_a2_q; end
			default: begin mul_a = x_q; mul_c = coef_b0_q; end
		endcase
	end

	assign mul_p = ACC_WIDTH'(mul_a) * ACC_WIDTH'(mul_c);

	// output: round half up, floor shift, clamp to sample range
	assign sum_y = (ACC_WIDTH+2)'(prod_q) + (ACC_WIDTH+2)'(delay_one_q) + RND_HALF;
	assign y_sh  = sum_y[ACC_WIDTH+1:COEF_FRAC];

	always_comb begin
		if (y_sh > DAT_MAX_X)
			y_sat = DAT_MAX_X[DATA_WIDTH-1:0];
		else if (y_sh < DAT_MIN_X)
			y_sat = DAT_MIN_X[DATA_WIDTH-1:0];
		else
			y_sat = y_sh[DATA_WIDTH-1:0];
	end

	// delay update: acc minus feedback product, clamp to accumulator range
	assign diff = (ACC_WIDTH+2)'(acc_q) - (ACC_WIDTH+2)'(prod_q);

	always_comb begin
		if (diff > ACC_MAX_X)
			d_sat = ACC_MAX_X[ACC_WIDTH-1:0];
		else if (diff < ACC_MIN_X)
			d_sat = ACC_MIN_X[ACC_WIDTH-1:0];
		else
			d_sat = diff[ACC_WIDTH-1:0];
	end

	// ---------------- sequencer ----------------
	assign sample_ch.ready = (state_q == S_IDLE);
	assign accept          = sample_ch.valid && sample_ch.ready;
	assign slot_free       = !out_vld_q || result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			delay_one_q <= '0;
			delay_two_q <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (state_q == S_PUSH && slot_free)
				out_vld_q <= 1'b1;
			else if (result_ch.ready)
				out_vld_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (sample_ch.clear_state) begin
							delay_one_q <= '0;
							delay_two_q <= '0;
						end
						state_q <= S_B0;
					end
				end
				S_B0: state_q <= S_Y;
				S_Y:  state_q <= S_A1;
				S_A1: state_q <= S_D1;
				S_D1: begin
					delay_one_q <= d_sat;
					state_q     <= S_B2;
				end
				S_B2: state_q <= S_D2;
				S_D2: begin
					delay_two_q <= d_sat;
					state_q     <= S_PUSH;
				end
				S_PUSH: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept)
					x_q <= sample_ch.sample_in;
			end
			S_B0: prod_q <= mul_p;
			S_Y: begin
				y_q    <= y_sat;
				prod_q <= mul_p;
			end
			S_A1: begin
				acc_q  <= (ACC_WIDTH+1)'(prod_q) + (ACC_WIDTH+1)'(delay_two_q);
				prod_q <= mul_p;
			end
			S_D1: prod_q <= mul_p;
			S_B2: begin
				acc_q  <= (ACC_WIDTH+1)'(prod_q);
				prod_q <= mul_p;
			end
			S_PUSH: begin
				if (slot_free)
					out_data_q <= y_q;
			end
			default: ;
		endcase
	end

	assign result_ch.valid      = out_vld_q;
	assign result_ch.sample_out = out_data_q;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the biquad filter unit. Coefficients are loaded
// over apb and read back. A directed table covers pass-through, the sample
// and coefficient extremes, saturation, the clear flag and an unmapped
// register. Random phases then run with fresh coefficient sets. Every
// output sample is compared with a table value or an in-bench fixed-point
// model, with random stalls on both channels and one long output hold.
// ----------------------------------------------------------------------------
module testbench;
	import bqd_pkg::*;

	localparam int DW          = DATA_WIDTH_DEF;
	localparam int CW          = COEF_WIDTH_DEF;
	localparam int ACC_W       = DW + CW;
	localparam int FRAC        = CW - COEF_INT_BITS;
	localparam int NUM_ROWS    = 32;
	localparam int NUM_PHASES  = 9;
	localparam int PHASE_ITEMS = 100;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT = 200000;

	// no register sits at this index, writes there must be dropped
	localparam logic [2:0] REG_UNMAPPED = 3'd5;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

	typedef struct packed {
		row_kind_e     kind;
		logic [2:0]    idx;
		logic [31:0]   value;
		logic          clr;
		logic          chk;
		logic [DW-1:0] exp;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	bqd_sample_if sample_ch ();
	bqd_result_if result_ch ();

	biquad_iir_filter_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #4 clk = ~clk;

	// filter model state and coefficient shadow
	logic signed [CW-1:0]    coef_q [NUM_COEFS];
	logic signed [ACC_W-1:0] z1_acc;
	logic signed [ACC_W-1:0] z2_acc;

	logic signed [DW-1:0] expected_samples [$];
	logic signed [DW-1:0] front_sample;
	int unsigned samples_in_count  = 0;
	int unsigned samples_out_count = 0;
	int unsigned err_count         = 0;
	int unsigned cycle_count       = 0;
	bit idle_on  = 1'b1;
	bit hold_req = 1'b0;

	stim_row_t stim_rows [NUM_ROWS] = '{
		// pass-through after reset
		'{ROW_ITEM, 3'd0, 32'h007F_FFFF, 1'b1, 1'b1, 24'h7F_FFFF},
		'{ROW_ITEM, 3'd0, 32'h0080_0000, 1'b0, 1'b1, 24'h80_0000},
		'{ROW_ITEM, 3'd0, 32'h0000_0000, 1'b0, 1'b1, 24'h00_0000},
		'{ROW_ITEM, 3'd0, 32'h0000_0001, 1'b0, 1'b1, 24'h00_0001},
		'{ROW_ITEM, 3'd0, 32'h00FF_FFFF, 1'b0, 1'b1, 24'hFF_FFFF},
		'{ROW_ITEM, 3'd0, 32'h0055_5555, 1'b0, 1'b1, 24'h55_5555},
		'{ROW_ITEM, 3'd0, 32'h00AA_AAAA, 1'b0, 1'b1, 24'hAA_AAAA},
		// b0 near +8.0, output clamps
		'{ROW_REG,  REG_B0, 32'h7FFF_FFFF, 1'b0, 1'b0, 24'h00_0000},
		'{ROW_ITEM, 3'd0, 32'h007F_FFFF, 1'b0, 1'b1, 24'h7F_FFFF},
		'{ROW_ITEM, 3'd0, 32'h0080_0000, 1'b0, 1'b1, 24'h80_0000},
		'{ROW_ITEM, 3'd0, 32'h0000_0001, 1'b0, 1'b1, 24'h00_0008},
		// b0 = -8.0
		'{ROW_REG,  REG_B0, 32'h8000_0000, 1'b0, 1'b0, 24'h00_0000},
		'{ROW_ITEM, 3'd0, 32'h007F_FFFF, 1'b0, 1'b1, 24'h80_0000},
		'{ROW_ITEM, 3'd0, 32'h0080_0000, 1'b0, 1'b1, 24'h7F_FFFF},
		'{ROW_ITEM, 3'd0, 32'h00FF_FFFF, 1'b1, 1'b1, 24'h00_0008},
		// extreme taps on b1, b2, a1 and a2, delays run into their limits
		'{ROW_REG,  REG_B0, 32'h1000_0000, 1'b0, 1'b0, 24'h00_0000},
		'{ROW_REG,  REG_B1, 32'h8000_0000, 1'b0, 1'b0, 24'h00_0000},
		'{ROW_REG,  REG_B2, 32'h7FFF_FFFF, 1'b0, 1'b0, 24'h00_0000},
		'{ROW_REG,  REG_A1, 32'h7FFF_FFFF, 1'b0, 1'b0, 24'h00_0000},
		'{ROW_REG,  REG_A2, 32'h8000_0000, 1'b0, 1'b0, 24'h00_0000},
		'{ROW_ITEM, 3'd0, 32'h007F_FFFF, 1'b1, 1'b0, 24'h00_0000},
		'{ROW_ITEM, 3'd0, 32'h0080_0000, 1'b0, 1'b0, 24'h00_0000},
		'{ROW_ITEM, 3'd0, 32'h007F_FFFF, 1'b0, 1'b0, 24'h00_0000},
		'{ROW_ITEM, 3'd0, 32'h0080_0000, 1'b0, 1'b0, 24'h00_0000},
		'{ROW_ITEM, 3'd0, 32'h0000_0000, 1'b0, 1'b0, 24'h00_0000},
		'{ROW_ITEM, 3'd0, 32'h0012_3456, 1'b1, 1'b0, 24'h00_0000},
		// unmapped write leaves the taps alone
		'{ROW_REG,  REG_UNMAPPED, 32'hDEAD_BEEF, 1'b0, 1'b0, 24'h00_0000},
		'{ROW_ITEM, 3'd0, 32'h007F_FFFF, 1'b0, 1'b0, 24'h00_0000},
		'{ROW_ITEM, 3'd0, 32'h0080_0000, 1'b1, 1'b0, 24'h00_0000},
		'{ROW_REG,  REG_A1, 32'h0000_0000, 1'b0, 1'b0, 24'h00_0000},
		'{ROW_REG,  REG_A2, 32'h0000_0000, 1'b0, 1'b0, 24'h00_0000},
		'{ROW_ITEM, 3'd0, 32'h003F_FFFF, 1'b0, 1'b0, 24'h00_0000}
	};

	function automatic longint clamp_to(input longint v, input int w);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			return hi;
		end
		if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	// one step of the transposed direct form ii section, quantized y fed back
	function automatic logic signed [DW-1:0] biquad_predict(
		input logic signed [DW-1:0] x,
		input logic                 clr
	);
		longint xs;
		longint acc;
		longint y;
		xs = longint'(x);
		if (clr) begin
			z1_acc = '0;
			z2_acc = '0;
		end
		acc = longint'(coef_q[REG_B0]) * xs + longint'(z1_acc);
		y   = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
		y   = clamp_to(y, DW);
		z1_acc = ACC_W'(clamp_to(longint'(coef_q[REG_B1]) * xs
			- longint'(coef_q[REG_A1]) * y + longint'(z2_acc), ACC_W));
		z2_acc = ACC_W'(clamp_to(longint'(coef_q[REG_B2]) * xs
			- longint'(coef_q[REG_A2]) * y, ACC_W));
		return y[DW-1:0];
	endfunction

	// apb write followed by a read of the same address
	task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx < NUM_COEFS) begin
			coef_q[idx] = value;
			if (prdata !== value) begin
				err_count++;
				$display("%0t: readback reg %0d expected %h actual %h", $time, idx, value,
					prdata);
			end
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_item(
		input logic signed [DW-1:0] s,
		input logic                 clr,
		input logic                 chk,
		input logic signed [DW-1:0] typed
	);
		logic signed [DW-1:0] pred;
		sample_ch.valid       <= 1'b1;
		sample_ch.sample_in   <= s;
		sample_ch.clear_state <= clr;
		do @(posedge clk); while (!sample_ch.ready);
		pred = biquad_predict(s, clr);
		expected_samples.push_back(chk ? typed : pred);
		samples_in_count++;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			sample_ch.valid       <= 1'b0;
			sample_ch.sample_in   <= DW'($urandom);
			sample_ch.clear_state <= 1'($urandom_range(0, 1));
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		while (samples_out_count != samples_in_count) @(posedge clk);
	endtask

	// output side: random stalls plus one long hold while the input backs up
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 9) - 1) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			samples_out_count++;
			if (expected_samples.size() == 0) begin
				err_count++;
				$display("%0t: sample_out %0d with nothing expected", $time,
					result_ch.sample_out);
			end else begin
				front_sample = expected_samples.pop_front();
				if (result_ch.sample_out !== front_sample) begin
					err_count++;
					$display("%0t: sample_out expected %0d actual %0d", $time, front_sample,
						result_ch.sample_out);
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout after %0d cycles", $time, cycle_count);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		logic signed [DW-1:0] s;
		logic [31:0]          cval;
		arst_n                <= 1'b0;
		psel                  <= 1'b0;
		penable               <= 1'b0;
		pwrite                <= 1'b0;
		paddr                 <= '0;
		pwdata                <= '0;
		sample_ch.valid       <= 1'b0;
		sample_ch.sample_in   <= '0;
		sample_ch.clear_state <= 1'b0;
		coef_q[REG_B0] = 32'sh1000_0000;
		coef_q[REG_B1] = '0;
		coef_q[REG_B2] = '0;
		coef_q[REG_A1] = '0;
		coef_q[REG_A2] = '0;
		z1_acc = '0;
		z2_acc = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_ROWS; i++) begin
			if (stim_rows[i].kind == ROW_REG) begin
				wait_drained();
				reg_write(stim_rows[i].idx, stim_rows[i].value);
			end else begin
				send_item(stim_rows[i].value[DW-1:0], stim_rows[i].clr, stim_rows[i].chk,
					stim_rows[i].exp);
			end
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			for (int r = 0; r < NUM_COEFS; r++) begin
				case (p % 3)
					0: begin
						// roughly within +-1.0
						cval = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
					end
					1: begin
						cval = $urandom;
					end
					default: begin
						case ($urandom_range(0, 4))
							0: cval = 32'h7FFF_FFFF;
							1: cval = 32'h8000_0000;
							2: cval = 32'h0000_0000;
							3: cval = 32'h1000_0000;
							default: cval = 32'hF000_0000;
						endcase
					end
				endcase
				reg_write(3'(r), cval);
			end
			idle_on = (p != 4) && (p != NUM_PHASES - 1);
			if (p == 1) begin
				hold_req = 1'b1;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				case ($urandom_range(0, 7))
					0: s = 24'h7F_FFFF;
					1: s = 24'h80_0000;
					2: s = DW'($urandom_range(0, 511)) - 24'd256;
					default: s = DW'($urandom);
				endcase
				send_item(s, $urandom_range(0, 15) == 0, 1'b0, '0);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && expected_samples.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
